### hdl/lpht_pkg.sv
// ============================================================================
// lpht_pkg : shared types and constants for the linear-probe hash table
// Request/response beat structs, operation and status codes, FSM states.
// ============================================================================
package lpht_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISS     = 3'd4,
        ST_DELETED  = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] hash_value;
        logic [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [7:0]  slot_index;
        logic [8:0]  entry_total;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_NXT,
        S_DONE,
        S_CLR
    } t_state;

endpackage

### hdl/lpht_ram.sv
// ============================================================================
// lpht_ram : generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/lpht_front.sv
// ============================================================================
// lpht_front : request intake
// Two-entry queue of request beats; reduces the hash to a home slot.
// ============================================================================
module lpht_front
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_req                     i_req,
    output logic                     o_valid,
    input  logic                     i_take,
    output t_req                     o_req,
    output logic [$clog2(SLOTS)-1:0] o_home
);
    localparam int AW   = $clog2(SLOTS);
    localparam bit POW2 = (SLOTS == (1 << AW));

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    logic       ready;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0) && ready;
    assign pop     = o_valid && i_take;
    assign o_req   = r_q[r_rp];

    generate
        if (POW2) begin : g_mask
            assign ready  = 1'b1;
            assign o_home = o_req.hash_value[AW-1:0];
        end else begin : g_reduce
            // head hash mod SLOTS: compare and subtract SLOTS << j from the top
            // shift down to zero, four steps per cycle
            localparam int JTOP  = 33 - AW;
            localparam int NSTEP = JTOP + 1;
            localparam int NCYC  = (NSTEP + 3) / 4;
            localparam int SW    = $clog2(NCYC + 1);
            localparam logic [33:0] DIV_TOP = 34'(SLOTS) << JTOP;

            logic [31:0]   r_rem;
            logic [33:0]   r_div;
            logic [SW-1:0] r_cyc;
            logic          r_busy, r_done;
            logic [31:0]   n_rem;
            logic [33:0]   n_div;

            always_comb begin
                n_rem = r_rem;
                n_div = r_div;
                for (int k = 0; k < 4; k++) begin
                    if ((int'(r_cyc) * 4 + k < NSTEP) && ({2'b00, n_rem} >= n_div)) begin
                        n_rem = n_rem - n_div[31:0];
                    end
                    n_div = n_div >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else if (pop) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                end else if (r_cnt != 2'd0 && !r_busy && !r_done) begin
                    r_busy <= 1'b1;
                    r_rem  <= o_req.hash_value;
                    r_div  <= DIV_TOP;
                    r_cyc  <= '0;
                end else if (r_busy) begin
                    r_rem <= n_rem;
                    r_div <= n_div;
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == SW'(NCYC - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end

            assign ready  = r_done;
            assign o_home = r_rem[AW-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

### hdl/lpht_back.sv
// ============================================================================
// lpht_back : probe engine
// Walks the probe run one slot per memory read, updates the table,
// holds the response in an output register.
// ============================================================================
module lpht_back
    import lpht_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_take,
    input  t_req                     i_req,
    input  logic [$clog2(SLOTS)-1:0] i_home,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_rsp                     o_rsp
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS+1);

    t_state r_state, n_state;

    logic [AW-1:0]         r_slot, r_free, r_del, r_clr;
    logic [CW-1:0]         r_probes;
    logic                  r_have_free;
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_live;
    logic                  r_ovalid;
    t_rsp                  r_rsp;

    logic                  we_k, we_f;
    logic [AW-1:0]         addr;
    logic [KEY_BITS-1:0]   wkey, rkey;
    logic [VALUE_BITS-1:0] wval, rval;
    logic [1:0]            wflag, rflag;
    logic                  we;

    logic [AW-1:0] nxt;
    logic          occ, tomb, hit, last, out_free;

    lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
        .i_clk(i_clk), .i_we(we_k), .i_addr(addr), .i_wdata(wkey), .o_rdata(rkey));
    lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wval), .o_rdata(rval));
    // {occupied, tombstone} per slot
    lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_flag (
        .i_clk(i_clk), .i_we(we_f), .i_addr(addr), .i_wdata(wflag), .o_rdata(rflag));

    assign nxt  = (r_slot == AW'(SLOTS-1)) ? '0 : r_slot + 1'b1;
    assign occ  = rflag[1];
    assign tomb = rflag[0];
    assign hit  = occ && (rkey == r_key);
    assign last = (r_probes == CW'(SLOTS-1));
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AW'(SLOTS-1)) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = (t_op'(i_req.operation) == OP_NONE) ? S_DONE : S_RD;
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (hit && t_op'(r_op) == OP_DELETE) n_state = S_NXT;
                else if (hit || (!occ && !tomb) || last) n_state = S_DONE;
                else n_state = S_RD;
            end
            // delete reads the flags of the following slot
            S_NXT:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // insert of a new key goes through the free slot found during the probe
    always_comb begin
        o_take = (r_state == S_IDLE);
        we     = 1'b0;
        we_k   = 1'b0;
        we_f   = 1'b0;
        addr   = r_slot;
        wkey   = r_key;
        wval   = r_val;
        wflag  = 2'b00;
        if (r_state == S_CLR) begin
            we_f = 1'b1;
            addr = r_clr;
        end
        if (r_state == S_CHK && hit && t_op'(r_op) == OP_INSERT) begin
            we = 1'b1;
        end
        if (r_state == S_DONE && out_free && t_op'(r_op) == OP_INSERT
            && r_rsp.status == ST_NEW) begin
            we    = 1'b1;
            we_k  = 1'b1;
            we_f  = 1'b1;
            addr  = r_free;
            wflag = 2'b10;
        end
        // rflag holds the next slot's flags here
        if (r_state == S_DONE && out_free && r_rsp.status == ST_DELETED) begin
            we_f  = 1'b1;
            addr  = r_del;
            wflag = {1'b0, rflag[1] || rflag[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op   <= i_req.operation;
            r_key  <= KEY_BITS'(i_req.key);
            r_val  <= VALUE_BITS'(i_req.item_value);
            r_slot <= i_home;
            r_probes <= '0;
            r_have_free <= 1'b0;
            r_rsp  <= '{status: ST_MISS, found_value: '0, slot_index: '0, entry_total: '0};
        end
        if (r_state == S_CHK) begin
            if (t_op'(r_op) == OP_INSERT) begin
                if (!occ && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free <= r_slot;
                end
                if (hit) begin
                    r_rsp.status     <= ST_REPLACED;
                    r_rsp.slot_index <= 8'(r_slot);
                end else if ((!occ && !tomb) || last) begin
                    if (r_have_free || !occ) begin
                        r_rsp.status     <= ST_NEW;
                        r_rsp.slot_index <= 8'(r_have_free ? r_free : r_slot);
                    end else begin
                        r_rsp.status <= ST_FULL;
                    end
                end
            end else if (hit) begin
                r_rsp.slot_index <= 8'(r_slot);
                if (t_op'(r_op) == OP_LOOKUP) begin
                    r_rsp.status      <= ST_FOUND;
                    r_rsp.found_value <= 32'(rval);
                end else begin
                    r_rsp.status <= ST_DELETED;
                end
            end
            if (hit) r_del <= r_slot;
            r_slot   <= nxt;
            r_probes <= r_probes + 1'b1;
        end
        if (r_state == S_DONE && out_free) begin
            r_rsp <= r_rsp;
        end
        if (out_free) begin
            o_rsp <= '{status: r_rsp.status, found_value: r_rsp.found_value,
                       slot_index: r_rsp.slot_index,
                       entry_total: 9'(r_live
                           + CW'(r_rsp.status == ST_NEW)
                           - CW'(r_rsp.status == ST_DELETED))};
        end
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                if (r_rsp.status == ST_NEW) begin
                    r_live <= r_live + 1'b1;
                end else if (r_rsp.status == ST_DELETED) begin
                    r_live <= r_live - 1'b1;
                end
            end
        end
    end

    assign o_valid = r_ovalid;
endmodule

### hdl/linear_probe_hash_table.sv
// ============================================================================
// linear_probe_hash_table : open-addressing table with linear probing
// Top level: request intake queue feeding the probe engine.
// ============================================================================
// Usage:
//   Request channel i_valid/o_stall carries one t_req beat (operation, key,
//   hash, value); response channel o_valid/i_stall returns one t_rsp beat
//   per request, in order.
//   A two-beat intake queue accepts requests while the probe engine works.
//   Each probe is a registered RAM read, then the compare; a request walks
//   its run of probed slots this way, a delete that hits also reads the
//   next slot's flags, and an unused operation code goes straight to the
//   response without probing.
//   A non-power-of-two SLOTS adds a home-slot reduction per beat in the
//   intake.
//   The response sits in an output register; while i_stall is high it holds
//   and the engine waits with the next result.
//   Reset clears the live count, the intake queue and the output valid,
//   then a pass over every slot zeroes the occupancy/tombstone RAM; two
//   beats are taken in that time, then the input stalls. Key and value
//   RAMs need no clearing since only occupied slots are ever compared.
// ============================================================================
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
    logic                     q_valid, q_take;
    t_req                     q_req;
    logic [$clog2(SLOTS)-1:0] q_home;

    lpht_front #(.SLOTS(SLOTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(q_valid), .i_take(q_take), .o_req(q_req),
        .o_home(q_home));

    lpht_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_req(q_req), .i_home(q_home), .o_valid(o_valid), .i_stall(i_stall),
        .o_rsp(o_rsp));
endmodule

### hdl/lpht_checker.sv
// ============================================================================
// lpht_checker : port-level checks for the hash table
// Response sanity as seen on the ports: hold under stall, status code, found_value, slot_index.
// ============================================================================
module lpht_checker
    import lpht_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed under stall");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= ST_DELETED)
        else $error("bad status code");

    a_fv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_FOUND |-> o_rsp.found_value == '0)
        else $error("found_value nonzero without a hit");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_MISS)
        |-> o_rsp.slot_index == '0)
        else $error("slot_index set on a miss");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_rsp(o_rsp));
